### src/polygon_closest_segment_hit_defines.svh
// Assertion macros for the polygon closest segment hit block.
// Included by files that carry concurrent checks; needs a clock i_clk and reset i_rst_n.
`ifndef POLYGON_CLOSEST_SEGMENT_HIT_DEFINES_SVH
`define POLYGON_CLOSEST_SEGMENT_HIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PCSH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PCSH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCSH_ASSERT_IMP(lbl, ante, cons, msg)
`define PCSH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/pcsh_pkg.sv
// Shared types and constants for the polygon closest segment hit block.
// No dependencies; imported by every module of the block.
package pcsh_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int FIX_FRAC         = 8;
    localparam int DRAIN_CYCLES     = 8;
    localparam logic [33:0] AREA_CAP = 34'h2_0000_0000;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DRAIN,
        S_DIVPREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x_a;
        logic signed [15:0] y_a;
        logic signed [15:0] x_b;
        logic signed [15:0] y_b;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [5:0]         edge_index;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [33:0]        area_twice;
        logic               clockwise;
    } t_out_item;

    // flags that travel with an edge from the edge cell to the pick cell
    typedef struct packed {
        logic valid;
        logic close;
        logic cand;
    } t_edge_flags;

endpackage

### src/pcsh_vstore.sv
// Vertex memory: one write port, one registered read port.
// Uses pcsh_pkg for parameter defaults.
module pcsh_vstore #(
    parameter int MAX_V = pcsh_pkg::MAX_VERTICES_DEF,
    parameter int CW    = pcsh_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(MAX_V)-1:0] i_wr_addr,
    input  logic [CW-1:0]            i_wr_x,
    input  logic [CW-1:0]            i_wr_y,
    input  logic                     i_rd_en,
    input  logic [$clog2(MAX_V)-1:0] i_rd_addr,
    input  logic                     i_rd_close,
    output logic                     o_rd_valid,
    output logic                     o_rd_close,
    output logic [CW-1:0]            o_rd_x,
    output logic [CW-1:0]            o_rd_y
);
    import pcsh_pkg::*;

    logic [CW-1:0] r_mem_x [MAX_V];
    logic [CW-1:0] r_mem_y [MAX_V];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_x[i_wr_addr] <= i_wr_x;
            r_mem_y[i_wr_addr] <= i_wr_y;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_x <= r_mem_x[i_rd_addr];
            o_rd_y <= r_mem_y[i_rd_addr];
        end
        o_rd_close <= i_rd_close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= i_rd_en;
        end
    end

endmodule

### src/pcsh_edge_cell.sv
// Edge cell: pairs consecutive vertices into edges and forms the intersection
// terms and shoelace terms in three register stages. Uses pcsh_pkg.
module pcsh_edge_cell #(
    parameter int MAX_V = pcsh_pkg::MAX_VERTICES_DEF,
    parameter int CW    = pcsh_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_v_valid,
    input  logic                     i_v_close,
    input  logic [CW-1:0]            i_v_x,
    input  logic [CW-1:0]            i_v_y,
    input  logic signed [CW-1:0]     i_q_ax,
    input  logic signed [CW-1:0]     i_q_ay,
    input  logic signed [CW:0]       i_q_dx,
    input  logic signed [CW:0]       i_q_dy,
    output pcsh_pkg::t_edge_flags    o_flags,
    output logic [2*CW:0]            o_sn,
    output logic [2*CW:0]            o_den,
    output logic [2*CW:0]            o_tn,
    output logic [$clog2(MAX_V)-1:0] o_idx,
    output logic signed [CW-1:0]     o_e1x,
    output logic signed [CW-1:0]     o_e1y,
    output logic signed [CW:0]       o_adx,
    output logic signed [CW:0]       o_ady,
    output logic signed [2*CW+1:0]   o_term_s,
    output logic signed [2*CW+1:0]   o_term_t
);
    import pcsh_pkg::*;

    localparam int P  = 2 * CW + 2;
    localparam int MW = P - 1;
    localparam int IW = $clog2(MAX_V);

    // previous vertex and edge counter
    logic                 r_have_prev;
    logic [IW-1:0]        r_edge_cnt;
    logic signed [CW-1:0] r_px, r_py;

    // stage 1
    logic                 r1_valid, r1_close;
    logic [IW-1:0]        r1_idx;
    logic signed [CW-1:0] r1_e1x, r1_e1y, r1_x1, r1_y1;
    logic signed [CW:0]   r1_adx, r1_ady, r1_cx, r1_cy, r1_sy;

    // stage 2
    logic                 r2_valid, r2_close;
    logic [IW-1:0]        r2_idx;
    logic signed [CW-1:0] r2_e1x, r2_e1y;
    logic signed [CW:0]   r2_adx, r2_ady;
    logic signed [P-1:0]  r2_pa, r2_pb, r2_pc, r2_pd, r2_pe, r2_pf;
    logic signed [P-1:0]  r2_ra, r2_rb, r2_rc;

    // stage 3 flags
    logic                 r3_valid, r3_close, r3_cand;

    logic                 w_form;
    logic signed [P-1:0]  w_den, w_tn, w_sn, w_dn, w_tnn, w_snn;
    logic                 w_cand;

    assign w_form = i_v_valid && r_have_prev;

    // vertex pairing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_edge_cnt  <= '0;
        end else if (i_clear) begin
            r_have_prev <= 1'b0;
            r_edge_cnt  <= '0;
        end else if (i_v_valid) begin
            r_have_prev <= 1'b1;
            if (r_have_prev) begin
                r_edge_cnt <= r_edge_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_v_valid) begin
            r_px <= i_v_x;
            r_py <= i_v_y;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= w_form;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // stage 1: edge vector, offset from query start
    always_ff @(posedge i_clk) begin
        r1_close <= i_v_close;
        r1_idx   <= r_edge_cnt;
        r1_e1x   <= r_px;
        r1_e1y   <= r_py;
        r1_x1    <= i_v_x;
        r1_y1    <= i_v_y;
        r1_adx   <= {i_v_x[CW-1], i_v_x} - {r_px[CW-1], r_px};
        r1_ady   <= {i_v_y[CW-1], i_v_y} - {r_py[CW-1], r_py};
        r1_cx    <= {r_px[CW-1], r_px} - {i_q_ax[CW-1], i_q_ax};
        r1_cy    <= {r_py[CW-1], r_py} - {i_q_ay[CW-1], i_q_ay};
        r1_sy    <= {i_v_y[CW-1], i_v_y} + {r_py[CW-1], r_py};
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        r2_close <= r1_close;
        r2_idx   <= r1_idx;
        r2_e1x   <= r1_e1x;
        r2_e1y   <= r1_e1y;
        r2_adx   <= r1_adx;
        r2_ady   <= r1_ady;
        r2_pa    <= r1_ady * i_q_dx;
        r2_pb    <= r1_adx * i_q_dy;
        r2_pc    <= i_q_dy * r1_cx;
        r2_pd    <= i_q_dx * r1_cy;
        r2_pe    <= r1_adx * r1_cy;
        r2_pf    <= r1_ady * r1_cx;
        r2_ra    <= r1_e1x * r1_y1;
        r2_rb    <= r1_x1 * r1_e1y;
        r2_rc    <= r1_adx * r1_sy;
    end

    // stage 3: determinants, sign fold, bounds check
    always_comb begin
        w_den = r2_pa - r2_pb;
        w_tn  = r2_pc - r2_pd;
        w_sn  = r2_pe - r2_pf;
        if (w_den[P-1]) begin
            w_dn  = -w_den;
            w_tnn = -w_tn;
            w_snn = -w_sn;
        end else begin
            w_dn  = w_den;
            w_tnn = w_tn;
            w_snn = w_sn;
        end
        w_cand = (w_den != '0) && !w_tnn[P-1] && !w_snn[P-1]
              && (w_tnn[MW-1:0] <= w_dn[MW-1:0]) && (w_snn[MW-1:0] <= w_dn[MW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        r3_close <= r2_close;
        r3_cand  <= w_cand;
        o_sn     <= w_snn[MW-1:0];
        o_den    <= w_dn[MW-1:0];
        o_tn     <= w_tnn[MW-1:0];
        o_idx    <= r2_idx;
        o_e1x    <= r2_e1x;
        o_e1y    <= r2_e1y;
        o_adx    <= r2_adx;
        o_ady    <= r2_ady;
        o_term_s <= r2_ra - r2_rb;
        o_term_t <= r2_rc;
    end

    assign o_flags = {r3_valid, r3_close, r3_cand};

endmodule

### src/pcsh_pick_cell.sv
// Pick cell: keeps the nearest hit with a two-stage cross-multiplied compare,
// and accumulates the shoelace and orientation sums. Uses pcsh_pkg.
module pcsh_pick_cell #(
    parameter int MAX_V = pcsh_pkg::MAX_VERTICES_DEF,
    parameter int CW    = pcsh_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  pcsh_pkg::t_edge_flags    i_flags,
    input  logic [2*CW:0]            i_sn,
    input  logic [2*CW:0]            i_den,
    input  logic [2*CW:0]            i_tn,
    input  logic [$clog2(MAX_V)-1:0] i_idx,
    input  logic signed [CW-1:0]     i_e1x,
    input  logic signed [CW-1:0]     i_e1y,
    input  logic signed [CW:0]       i_adx,
    input  logic signed [CW:0]       i_ady,
    input  logic signed [2*CW+1:0]   i_term_s,
    input  logic signed [2*CW+1:0]   i_term_t,
    output logic                     o_found,
    output logic [$clog2(MAX_V)-1:0] o_idx,
    output logic [2*CW:0]            o_tn,
    output logic [2*CW:0]            o_den,
    output logic signed [CW-1:0]     o_e1x,
    output logic signed [CW-1:0]     o_e1y,
    output logic signed [CW:0]       o_adx,
    output logic signed [CW:0]       o_ady,
    output logic [33:0]              o_area,
    output logic                     o_clockwise
);
    import pcsh_pkg::*;

    localparam int P    = 2 * CW + 2;
    localparam int MW   = P - 1;
    localparam int H    = (MW + 1) / 2;
    localparam int LW   = MW - H;
    localparam int IW   = $clog2(MAX_V);
    localparam int ACW  = P + $clog2(MAX_V + 1);
    localparam int CAPW = (ACW > 35) ? ACW : 35;

    // stage 4 registers
    logic                 r4_take;
    logic [MW+H-1:0]      r4_p1l, r4_p2l;
    logic [MW+LW-1:0]     r4_p1h, r4_p2h;
    logic [MW-1:0]        r4_sn, r4_den, r4_tn;
    logic [IW-1:0]        r4_idx;
    logic signed [CW-1:0] r4_e1x, r4_e1y;
    logic signed [CW:0]   r4_adx, r4_ady;

    logic [MW-1:0]        r_bsn;
    logic signed [ACW-1:0] r_sum, r_tot;

    logic [2*MW-1:0]      w_a, w_b;
    logic [ACW-1:0]       w_abs;
    logic [CAPW-1:0]      w_abs_ext;

    // stage 4: partial products of the cross compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_take <= 1'b0;
        end else begin
            r4_take <= i_flags.valid && !i_flags.close && i_flags.cand && !i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_p1l <= i_sn * o_den[H-1:0];
        r4_p1h <= i_sn * o_den[MW-1:H];
        r4_p2l <= r_bsn * i_den[H-1:0];
        r4_p2h <= r_bsn * i_den[MW-1:H];
        r4_sn  <= i_sn;
        r4_den <= i_den;
        r4_tn  <= i_tn;
        r4_idx <= i_idx;
        r4_e1x <= i_e1x;
        r4_e1y <= i_e1y;
        r4_adx <= i_adx;
        r4_ady <= i_ady;
    end

    // stage 5: strict less wins, so a tie keeps the lower edge
    assign w_a = {r4_p1h, {H{1'b0}}} + (2 * MW)'(r4_p1l);
    assign w_b = {r4_p2h, {H{1'b0}}} + (2 * MW)'(r4_p2l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found <= 1'b0;
        end else if (i_clear) begin
            o_found <= 1'b0;
        end else if (r4_take && (!o_found || (w_a < w_b))) begin
            o_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_take && (!o_found || (w_a < w_b))) begin
            r_bsn <= r4_sn;
            o_den <= r4_den;
            o_tn  <= r4_tn;
            o_idx <= r4_idx;
            o_e1x <= r4_e1x;
            o_e1y <= r4_e1y;
            o_adx <= r4_adx;
            o_ady <= r4_ady;
        end
    end

    // shoelace and orientation accumulators; closing edge skips orientation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_tot <= '0;
        end else if (i_clear) begin
            r_sum <= '0;
            r_tot <= '0;
        end else if (i_flags.valid) begin
            r_sum <= r_sum + ACW'(i_term_s);
            if (!i_flags.close) begin
                r_tot <= r_tot + ACW'(i_term_t);
            end
        end
    end

    // magnitude with saturation
    always_comb begin
        w_abs     = r_sum[ACW-1] ? ACW'(-r_sum) : ACW'(r_sum);
        w_abs_ext = CAPW'(w_abs);
        o_area    = (w_abs_ext > CAPW'(AREA_CAP)) ? AREA_CAP : w_abs_ext[33:0];
    end

    assign o_clockwise = r_tot[ACW-1];

endmodule

### src/pcsh_div.sv
// Restoring divider, one quotient bit per cycle, for the hit point.
// Uses pcsh_pkg only through the import convention of the block.
module pcsh_div #(
    parameter int NW = 57,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_q,
    output logic          o_rem_nz
);
    import pcsh_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den, r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic [DW:0]     w_sh, w_diff;
    logic            w_ge;

    assign w_sh   = {r_rem, r_num[NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(NW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            o_q   <= '0;
        end else if (r_run) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            o_q   <= {o_q[NW-2:0], w_ge};
        end
    end

    assign o_rem_nz = (r_rem != '0);

endmodule

### src/polygon_closest_segment_hit.sv
// Polygon vertex table with nearest segment-edge hit and shape report.
// Input beat (i_in_valid / o_in_stall, t_in_item): kind 0 clears the table,
// kind 1 appends a vertex, kind 2 queries a segment, kind 3 reports the
// doubled shoelace area and clockwise flag. Clear and append give no result.
// Query and report each give one output beat (o_out_valid / i_out_stall,
// t_out_item).
// The vertex memory is read at the pace of the two-stage nearest-hit compare
// loop: a read is issued only while r_phase is low, so each edge is compared
// before the next one reaches the compare. A query that hits adds a serial
// division for the hit point.
// At most one item is in work; the input stalls until its result is handed
// to the output register. A result may wait there under output stall while
// the next item is already accepted and worked on; a second result then
// waits until the output register frees.
// Reset (synchronous, active low) empties the table and drops any pending
// result; stored vertices are undefined until appended.
`include "polygon_closest_segment_hit_defines.svh"
module polygon_closest_segment_hit #(
    parameter int MAX_VERTICES = pcsh_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pcsh_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pcsh_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pcsh_pkg::t_out_item o_out_data
);
    import pcsh_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int P     = 2 * CW + 2;
    localparam int MW    = P - 1;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VCW   = $clog2(MAX_VERTICES + 1);
    localparam int LW    = VCW + 1;
    localparam int NW    = CW + FIX_FRAC + MW;
    localparam int PW    = NW + 2;
    localparam int DCW   = $clog2(DRAIN_CYCLES + 1);

    // coordinate from the low COORD_BITS bits of a 16-bit field
    function automatic logic signed [CW-1:0] to_coord(input logic [15:0] f);
        logic [CW+15:0] t;
        t = {{CW{1'b0}}, f};
        return t[CW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [VCW-1:0]     r_vcount;
    logic               r_is_report;
    logic signed [CW-1:0] r_qax, r_qay;
    logic signed [CW:0] r_qdx, r_qdy;
    logic [LW-1:0]      r_issued, r_len;
    logic               r_phase;
    logic [DCW-1:0]     r_drain;
    logic               r_out_valid;
    t_out_item          r_out_data, w_result;

    logic               w_acc, w_start, w_rd_en, w_rd_close, w_wr_en, w_load;
    logic [AW-1:0]      w_rd_addr;
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;

    // vertex memory outputs
    logic               w_v_valid, w_v_close;
    logic [CW-1:0]      w_v_x, w_v_y;

    // edge cell to pick cell
    t_edge_flags        w_flags;
    logic [MW-1:0]      w_sn, w_den, w_tn;
    logic [AW-1:0]      w_idx;
    logic signed [CW-1:0] w_e1x, w_e1y;
    logic signed [CW:0] w_adx, w_ady;
    logic signed [P-1:0] w_term_s, w_term_t;

    // best hit
    logic               w_found, w_cw;
    logic [AW-1:0]      w_b_idx;
    logic [MW-1:0]      w_b_tn, w_b_den;
    logic signed [CW-1:0] w_b_e1x, w_b_e1y;
    logic signed [CW:0] w_b_adx, w_b_ady;
    logic [33:0]        w_area;

    // point division
    logic [CW:0]        w_magx, w_magy;
    logic [NW-1:0]      w_numx, w_numy, w_qx, w_qy;
    logic               w_dx_done, w_dy_done, w_rnzx, w_rnzy;
    logic signed [PW-1:0] w_px, w_py;

    assign w_ax = to_coord(i_in_data.x_a);
    assign w_ay = to_coord(i_in_data.y_a);
    assign w_bx = to_coord(i_in_data.x_b);
    assign w_by = to_coord(i_in_data.y_b);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign w_start    = w_acc && ((i_in_data.kind == KIND_QUERY)
                               || (i_in_data.kind == KIND_REPORT));
    assign w_wr_en    = w_acc && (i_in_data.kind == KIND_APPEND)
                     && (r_vcount < VCW'(MAX_VERTICES));

    // read issue: only while r_phase is low, report wraps back to vertex 0
    assign w_rd_en    = (r_state == S_FETCH) && !r_phase && (r_issued < r_len);
    assign w_rd_close = r_is_report && (r_issued == LW'(r_vcount));
    assign w_rd_addr  = w_rd_close ? '0 : r_issued[AW-1:0];

    assign w_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_issued == r_len) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == DCW'(DRAIN_CYCLES)) begin
                    n_state = (!r_is_report && w_found) ? S_DIVPREP : S_OUT;
                end
            end
            S_DIVPREP: n_state = S_DIV;
            S_DIV: begin
                if (w_dx_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (w_acc && (i_in_data.kind == KIND_CLEAR)) begin
            r_vcount <= '0;
        end else if (w_wr_en) begin
            r_vcount <= r_vcount + 1'b1;
        end
    end

    // item capture and fetch sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= '0;
            r_len    <= '0;
            r_phase  <= 1'b0;
            r_drain  <= '0;
        end else begin
            if (w_start) begin
                r_issued <= '0;
                r_phase  <= 1'b0;
                r_drain  <= '0;
                if (i_in_data.kind == KIND_REPORT) begin
                    r_len <= (r_vcount == '0) ? '0 : LW'(r_vcount) + 1'b1;
                end else begin
                    r_len <= LW'(r_vcount);
                end
            end else if (r_state == S_FETCH) begin
                r_phase <= !r_phase;
                if (w_rd_en) begin
                    r_issued <= r_issued + 1'b1;
                end
            end else if (r_state == S_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_is_report <= (i_in_data.kind == KIND_REPORT);
            r_qax       <= w_ax;
            r_qay       <= w_ay;
            r_qdx       <= {w_ax[CW-1], w_ax} - {w_bx[CW-1], w_bx};
            r_qdy       <= {w_ay[CW-1], w_ay} - {w_by[CW-1], w_by};
        end
    end

    pcsh_vstore #(.MAX_V(MAX_VERTICES), .CW(CW)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_vcount[AW-1:0]),
        .i_wr_x     (w_ax),
        .i_wr_y     (w_ay),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .i_rd_close (w_rd_close),
        .o_rd_valid (w_v_valid),
        .o_rd_close (w_v_close),
        .o_rd_x     (w_v_x),
        .o_rd_y     (w_v_y)
    );

    pcsh_edge_cell #(.MAX_V(MAX_VERTICES), .CW(CW)) u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_start),
        .i_v_valid (w_v_valid),
        .i_v_close (w_v_close),
        .i_v_x     (w_v_x),
        .i_v_y     (w_v_y),
        .i_q_ax    (r_qax),
        .i_q_ay    (r_qay),
        .i_q_dx    (r_qdx),
        .i_q_dy    (r_qdy),
        .o_flags   (w_flags),
        .o_sn      (w_sn),
        .o_den     (w_den),
        .o_tn      (w_tn),
        .o_idx     (w_idx),
        .o_e1x     (w_e1x),
        .o_e1y     (w_e1y),
        .o_adx     (w_adx),
        .o_ady     (w_ady),
        .o_term_s  (w_term_s),
        .o_term_t  (w_term_t)
    );

    pcsh_pick_cell #(.MAX_V(MAX_VERTICES), .CW(CW)) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_start),
        .i_flags     (w_flags),
        .i_sn        (w_sn),
        .i_den       (w_den),
        .i_tn        (w_tn),
        .i_idx       (w_idx),
        .i_e1x       (w_e1x),
        .i_e1y       (w_e1y),
        .i_adx       (w_adx),
        .i_ady       (w_ady),
        .i_term_s    (w_term_s),
        .i_term_t    (w_term_t),
        .o_found     (w_found),
        .o_idx       (w_b_idx),
        .o_tn        (w_b_tn),
        .o_den       (w_b_den),
        .o_e1x       (w_b_e1x),
        .o_e1y       (w_b_e1y),
        .o_adx       (w_b_adx),
        .o_ady       (w_b_ady),
        .o_area      (w_area),
        .o_clockwise (w_cw)
    );

    // numerators |d| * 256 * tn
    assign w_magx = w_b_adx[CW] ? -w_b_adx : w_b_adx;
    assign w_magy = w_b_ady[CW] ? -w_b_ady : w_b_ady;
    assign w_numx = {w_magx[CW-1:0], {FIX_FRAC{1'b0}}} * w_b_tn;
    assign w_numy = {w_magy[CW-1:0], {FIX_FRAC{1'b0}}} * w_b_tn;

    pcsh_div #(.NW(NW), .DW(MW)) u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DIVPREP),
        .i_num    (w_numx),
        .i_den    (w_b_den),
        .o_done   (w_dx_done),
        .o_q      (w_qx),
        .o_rem_nz (w_rnzx)
    );

    pcsh_div #(.NW(NW), .DW(MW)) u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DIVPREP),
        .i_num    (w_numy),
        .i_den    (w_b_den),
        .o_done   (w_dy_done),
        .o_q      (w_qy),
        .o_rem_nz (w_rnzy)
    );

    // point: base*256 plus quotient, floored for a negative direction
    always_comb begin
        if (w_b_adx[CW]) begin
            w_px = (PW'(w_b_e1x) <<< FIX_FRAC) - signed'({2'b00, w_qx}) - PW'(w_rnzx);
        end else begin
            w_px = (PW'(w_b_e1x) <<< FIX_FRAC) + signed'({2'b00, w_qx});
        end
        if (w_b_ady[CW]) begin
            w_py = (PW'(w_b_e1y) <<< FIX_FRAC) - signed'({2'b00, w_qy}) - PW'(w_rnzy);
        end else begin
            w_py = (PW'(w_b_e1y) <<< FIX_FRAC) + signed'({2'b00, w_qy});
        end
    end

    // result assembly
    always_comb begin
        w_result = '0;
        if (r_is_report) begin
            w_result.area_twice = w_area;
            w_result.clockwise  = w_cw;
        end else if (w_found) begin
            w_result.hit        = 1'b1;
            w_result.edge_index = 6'(w_b_idx);
            w_result.point_x    = w_px[23:0];
            w_result.point_y    = w_py[23:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `PCSH_ASSERT_IMP(a_count_bound, 1'b1, r_vcount <= VCW'(MAX_VERTICES), "vertex count overflow")
    `PCSH_ASSERT_IMP(a_div_only_hit, r_state == S_DIVPREP, w_found && !r_is_report, "division without hit")
    `PCSH_ASSERT_IMP(a_out_from_out, $rose(r_out_valid), $past(r_state) == S_OUT, "result outside output state")
    `PCSH_ASSERT_IMP(a_div_lockstep, 1'b1, w_dx_done == w_dy_done, "dividers out of step")
    `PCSH_ASSERT_IMP(a_fetch_bound, r_state == S_FETCH, r_issued <= r_len, "read beyond table")

endmodule
